[hdl/x86d_pkg.sv]
// x86d_pkg: shared types and opcode constants for the 16-bit x86 byte-stream decoder
// holds the record kind enum, the decoded record struct and the opcode patterns
// no dependencies
`timescale 1ns / 1ps

package x86d_pkg;

    // record kinds, value 15 never produced
    typedef enum logic [3:0] {
        KIND_MOV_RM       = 4'd0,
        KIND_ADD_RM       = 4'd1,
        KIND_SUB_RM       = 4'd2,
        KIND_CMP_RM       = 4'd3,
        KIND_MOV_IMM_REG  = 4'd4,
        KIND_MOV_IMM_RM   = 4'd5,
        KIND_ARITH_IMM_RM = 4'd6,
        KIND_ACC_LOAD     = 4'd7,
        KIND_ACC_STORE    = 4'd8,
        KIND_ADD_ACC      = 4'd9,
        KIND_SUB_ACC      = 4'd10,
        KIND_CMP_ACC      = 4'd11,
        KIND_JUMP         = 4'd12,
        KIND_UNSUP        = 4'd13,
        KIND_TRUNC        = 4'd14
    } t_kind;

    // one decoded instruction
    typedef struct packed {
        t_kind              kind;
        logic [7:0]         opcode_byte;
        logic               wide;
        logic               direction;
        logic               sign_extend;
        logic [1:0]         mode;
        logic [2:0]         reg_field;
        logic [2:0]         rm_field;
        logic signed [15:0] displacement;
        logic [15:0]        immediate;
        logic [2:0]         length;
    } t_rec;

    // opcode patterns, low bits masked off as noted
    localparam logic [7:0] OP_MOV_RM      = 8'h88; // mask fc
    localparam logic [7:0] OP_ADD_RM      = 8'h00; // mask fc
    localparam logic [7:0] OP_SUB_RM      = 8'h28; // mask fc
    localparam logic [7:0] OP_CMP_RM      = 8'h38; // mask fc
    localparam logic [7:0] OP_ARITH_IMM   = 8'h80; // mask fc
    localparam logic [7:0] OP_MOV_IMM_RM  = 8'hC6; // mask fe
    localparam logic [7:0] OP_ACC_LOAD    = 8'hA0; // mask fe
    localparam logic [7:0] OP_ACC_STORE   = 8'hA2; // mask fe
    localparam logic [7:0] OP_ADD_ACC     = 8'h04; // mask fe
    localparam logic [7:0] OP_SUB_ACC     = 8'h2C; // mask fe
    localparam logic [7:0] OP_CMP_ACC     = 8'h3C; // mask fe
    localparam logic [3:0] OP_MOV_IMM_REG = 4'hB;  // high nibble
    localparam logic [3:0] OP_JCC         = 4'h7;  // high nibble
    localparam logic [5:0] OP_LOOP        = 6'b111000; // e0 to e3

endpackage

[hdl/x86d_step.sv]
// x86d_step: per-byte decode step with the instruction phase and field holds
// classifies the opcode, collects modrm, displacement and data, builds the record
// depends on x86d_pkg
`timescale 1ns / 1ps

module x86d_step (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fire,
    input  logic [7:0]    i_code_byte,
    input  logic          i_eos,
    output logic          o_emit,
    output x86d_pkg::t_rec o_rec
);
    import x86d_pkg::*;

    // opcode classification
    function automatic t_kind classify(input logic [7:0] op);
        t_kind k;
        k = KIND_UNSUP;
        if (op[7:4] == OP_JCC || op[7:2] == OP_LOOP) begin
            k = KIND_JUMP;
        end else if (op[7:4] == OP_MOV_IMM_REG) begin
            k = KIND_MOV_IMM_REG;
        end else begin
            unique case ({op[7:1], 1'b0})
                OP_ACC_LOAD:   k = KIND_ACC_LOAD;
                OP_ACC_STORE:  k = KIND_ACC_STORE;
                OP_ADD_ACC:    k = KIND_ADD_ACC;
                OP_SUB_ACC:    k = KIND_SUB_ACC;
                OP_CMP_ACC:    k = KIND_CMP_ACC;
                OP_MOV_IMM_RM: k = KIND_MOV_IMM_RM;
                default: begin
                    unique case ({op[7:2], 2'b00})
                        OP_ARITH_IMM: k = KIND_ARITH_IMM_RM;
                        OP_MOV_RM:    k = KIND_MOV_RM;
                        OP_ADD_RM:    k = KIND_ADD_RM;
                        OP_SUB_RM:    k = KIND_SUB_RM;
                        OP_CMP_RM:    k = KIND_CMP_RM;
                        default:      k = KIND_UNSUP;
                    endcase
                end
            endcase
        end
        return k;
    endfunction

    function automatic logic has_modrm(input t_kind k);
        return (k <= KIND_CMP_RM) || (k == KIND_MOV_IMM_RM) || (k == KIND_ARITH_IMM_RM);
    endfunction

    // displacement bytes after the opcode or modrm byte
    function automatic logic [1:0] disp_len(input t_kind k, input logic [7:0] m);
        logic [1:0] dl;
        dl = 2'd0;
        if (has_modrm(k)) begin
            if (m[7:6] == 2'd1) begin
                dl = 2'd1;
            end else if (m[7:6] == 2'd2) begin
                dl = 2'd2;
            end else if (m[7:6] == 2'd0 && m[2:0] == 3'd6) begin
                dl = 2'd2;
            end
        end else if (k == KIND_ACC_LOAD || k == KIND_ACC_STORE) begin
            dl = 2'd2;
        end else if (k == KIND_JUMP) begin
            dl = 2'd1;
        end
        return dl;
    endfunction

    // immediate data bytes
    function automatic logic [1:0] data_len(input t_kind k, input logic [7:0] op);
        logic [1:0] n;
        n = 2'd0;
        if (k == KIND_MOV_IMM_REG) begin
            n = op[3] ? 2'd2 : 2'd1;
        end else if (k == KIND_MOV_IMM_RM || (k >= KIND_ADD_ACC && k <= KIND_CMP_ACC)) begin
            n = op[0] ? 2'd2 : 2'd1;
        end else if (k == KIND_ARITH_IMM_RM) begin
            n = (op[1:0] == 2'b01) ? 2'd2 : 2'd1;
        end
        return n;
    endfunction

    function automatic logic [15:0] sext8(input logic [7:0] v);
        return {{8{v[7]}}, v};
    endfunction

    logic [2:0]  r_count,  n_count;
    logic [2:0]  r_needed, n_needed;
    logic [7:0]  r_op,     n_op;
    logic [7:0]  r_modrm,  n_modrm;
    logic [15:0] r_disp,   n_disp;
    logic [15:0] r_data,   n_data;

    t_kind       kind;
    logic [2:0]  dstart;
    logic [2:0]  idx;
    logic [2:0]  idx_data;
    logic [1:0]  dl_cur;
    logic [1:0]  dl_out;
    logic [2:0]  cnt;
    logic        trunc;

    // byte step: update holds, decide completion or cut-off
    always_comb begin
        n_count  = r_count;
        n_needed = r_needed;
        n_op     = r_op;
        n_modrm  = r_modrm;
        n_disp   = r_disp;
        n_data   = r_data;
        kind     = classify(r_op);
        dstart   = has_modrm(kind) ? 3'd2 : 3'd1;
        dl_cur   = disp_len(kind, r_modrm);
        idx      = r_count - dstart;
        idx_data = idx - {1'b0, dl_cur};
        cnt      = r_count + 3'd1;
        o_emit   = 1'b0;
        trunc    = 1'b0;

        if (r_count == 3'd0) begin
            // opcode byte starts a fresh instruction
            n_op    = i_code_byte;
            n_modrm = 8'h00;
            n_disp  = 16'h0000;
            n_data  = 16'h0000;
            kind    = classify(i_code_byte);
            if (kind != KIND_UNSUP) begin
                n_needed = has_modrm(kind) ? 3'd2
                         : 3'd1 + {1'b0, disp_len(kind, 8'h00)}
                                + {1'b0, data_len(kind, i_code_byte)};
            end
        end else if (has_modrm(kind) && r_count == 3'd1) begin
            // modrm byte fixes the full length
            n_modrm  = i_code_byte;
            n_needed = 3'd2 + {1'b0, disp_len(kind, i_code_byte)}
                            + {1'b0, data_len(kind, r_op)};
        end else if (r_count >= dstart) begin
            // displacement bytes first, then data bytes
            if (idx < {1'b0, dl_cur}) begin
                if (idx == 3'd0) begin
                    n_disp[7:0] = i_code_byte;
                end else begin
                    n_disp[15:8] = i_code_byte;
                end
            end else if (idx_data == 3'd0) begin
                n_data[7:0] = i_code_byte;
            end else if (idx_data == 3'd1) begin
                n_data[15:8] = i_code_byte;
            end
        end

        if (r_count == 3'd0 && kind == KIND_UNSUP) begin
            o_emit = 1'b1;
        end else if (cnt >= n_needed) begin
            o_emit  = 1'b1;
            n_count = 3'd0;
        end else if (i_eos) begin
            o_emit  = 1'b1;
            trunc   = 1'b1;
            n_count = 3'd0;
            n_modrm = 8'h00;
            n_disp  = 16'h0000;
            n_data  = 16'h0000;
        end else begin
            n_count = cnt;
        end
    end

    // record assembly from the updated holds
    always_comb begin
        dl_out = disp_len(kind, n_modrm);
        o_rec  = '0;
        o_rec.opcode_byte = n_op;
        o_rec.length      = cnt;
        if (trunc) begin
            o_rec.kind = KIND_TRUNC;
        end else begin
            o_rec.kind = kind;
            if (kind <= KIND_CMP_ACC) begin
                o_rec.wide = (kind == KIND_MOV_IMM_REG) ? n_op[3] : n_op[0];
            end
            if (kind <= KIND_CMP_RM) begin
                o_rec.direction = n_op[1];
            end
            if (kind == KIND_ARITH_IMM_RM) begin
                o_rec.sign_extend = n_op[1];
            end
            if (has_modrm(kind)) begin
                o_rec.mode      = n_modrm[7:6];
                o_rec.reg_field = n_modrm[5:3];
                o_rec.rm_field  = n_modrm[2:0];
            end else if (kind == KIND_MOV_IMM_REG) begin
                o_rec.reg_field = n_op[2:0];
            end
            if (kind <= KIND_JUMP) begin
                if (dl_out == 2'd1) begin
                    o_rec.displacement = sext8(n_disp[7:0]);
                end else if (dl_out == 2'd2) begin
                    o_rec.displacement = n_disp;
                end
                if (kind == KIND_JUMP || kind <= KIND_CMP_RM || kind == KIND_ACC_LOAD
                    || kind == KIND_ACC_STORE) begin
                    o_rec.immediate = 16'h0000;
                end else if (kind == KIND_ARITH_IMM_RM && n_op[1] && n_op[0]) begin
                    o_rec.immediate = sext8(n_data[7:0]);
                end else begin
                    o_rec.immediate = n_data;
                end
            end
        end
    end

    // phase and hold registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= 3'd0;
            r_needed <= 3'd0;
            r_op     <= 8'h00;
            r_modrm  <= 8'h00;
            r_disp   <= 16'h0000;
            r_data   <= 16'h0000;
        end else if (i_fire) begin
            r_count  <= n_count;
            r_needed <= n_needed;
            r_op     <= n_op;
            r_modrm  <= n_modrm;
            r_disp   <= n_disp;
            r_data   <= n_data;
        end
    end

endmodule

[hdl/x86_16_instruction_decoder.sv]
// x86_16_instruction_decoder: top level with input register, decode step and result register
// streams code bytes in and decoded instruction records out
// depends on x86d_pkg and x86d_step
`timescale 1ns / 1ps

// Byte-stream decoder for a subset of 16-bit x86 code (mov, add, sub, cmp in register,
// memory, immediate and accumulator forms, conditional jumps, loops and jcxz). One code
// byte is taken per clock; a byte passes an input register, one decode step that updates
// the instruction phase and field holds, and a result register. The record's tvalid rises
// from the result register once the decode step has taken the byte that completes it.
// Records come one per instruction (1 to 6 bytes); an unknown opcode gives a one-byte
// unsupported record and a byte flagged with tlast that leaves an instruction open gives a
// truncated record. Throughput is one byte per cycle with no gaps; the only stall is a
// record held by the sink, which holds the decode step and, once the input register is
// full, the input as well.
module x86_16_instruction_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] code_byte
    input  logic        s_axis_tlast,  // end_of_stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,  // opcode_byte, wide, direction, sign_extend, mode,
                                       // reg_field, rm_field, displacement, immediate,
                                       // length, zero pad
    output logic [3:0]  m_axis_tuser   // kind
);
    import x86d_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eos;
    logic       r_out_valid;
    t_rec       r_out_rec;

    logic       out_free;
    logic       step_fire;
    logic       step_emit;
    t_rec       step_rec;

    // handshake control
    assign out_free      = !r_out_valid || m_axis_tready;
    assign step_fire     = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || step_fire;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (step_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_eos  <= s_axis_tlast;
        end
    end

    // decode step
    x86d_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (step_fire),
        .i_code_byte (r_in_byte),
        .i_eos       (r_in_eos),
        .o_emit      (step_emit),
        .o_rec       (step_rec)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step_fire && step_emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_fire && step_emit) begin
            r_out_rec <= step_rec;
        end
    end

    // output packing
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_rec.kind;
    assign m_axis_tdata  = {2'b00,
                            r_out_rec.length,
                            r_out_rec.immediate,
                            r_out_rec.displacement,
                            r_out_rec.rm_field,
                            r_out_rec.reg_field,
                            r_out_rec.mode,
                            r_out_rec.sign_extend,
                            r_out_rec.direction,
                            r_out_rec.wide,
                            r_out_rec.opcode_byte};

`ifndef NO_ASSERTIONS
    // a byte flagged as end of stream always closes with a record
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step_fire && r_in_eos) |=> r_out_valid)
        else $error("end of stream byte produced no record");

    // record lengths stay within one to six bytes
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_rec.length != 3'd0 && r_out_rec.length <= 3'd6))
        else $error("record length out of range");

    // unsupported opcodes consume exactly one byte
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_rec.kind == KIND_UNSUP) |-> (r_out_rec.length == 3'd1))
        else $error("unsupported record with length other than one");
`endif

endmodule

[tb/x86_16_instruction_decoder_tb.sv]
// x86_16_instruction_decoder_tb: self-checking bench for the byte-stream x86 decoder
// drives code bytes with random gaps, predicts each decoded record and checks every transfer
// depends on x86d_pkg and x86_16_instruction_decoder
`timescale 1ns / 1ps

module x86_16_instruction_decoder_tb;

    import x86d_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_BYTES = 1000;
    localparam int IDLE_PCT     = 34;
    localparam int CALM_FROM    = 800;
    localparam int CALM_TO      = 1400;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] code_byte
    logic        s_axis_tlast = 1'b0;    // end_of_stream
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;           // [7:0] opcode_byte, [8] wide, [9] direction,
                                         // [10] sign_extend, [12:11] mode, [15:13] reg_field,
                                         // [18:16] rm_field, [34:19] displacement,
                                         // [50:35] immediate, [53:51] length, zero pad
    logic [3:0]  m_axis_tuser;           // [3:0] kind

    // code bytes still to send, {tlast, byte}
    logic [8:0] code_queue[$];
    // decoded records still owed by the block
    t_rec       pending_records[$];

    int code_total = 0;
    int code_sent = 0;
    int errors = 0;
    int stall_cycles = 0;
    int cyc = 0;
    logic calm;

    // shadow of the decoder state
    logic [2:0]  byte_count = '0;
    logic [2:0]  needed_length = '0;
    logic [7:0]  opcode_hold = '0;
    logic [7:0]  modrm_hold = '0;
    logic [15:0] disp_hold = '0;
    logic [15:0] data_hold = '0;

    x86_16_instruction_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    assign calm = (cyc >= CALM_FROM) && (cyc < CALM_TO);

    // opcode to record kind
    function automatic t_kind opcode_kind(logic [7:0] op);
        if (op[7:4] == OP_JCC || op[7:2] == OP_LOOP) return KIND_JUMP;
        if (op[7:4] == OP_MOV_IMM_REG) return KIND_MOV_IMM_REG;
        case (op & 8'hFE)
            OP_ACC_LOAD:   return KIND_ACC_LOAD;
            OP_ACC_STORE:  return KIND_ACC_STORE;
            OP_ADD_ACC:    return KIND_ADD_ACC;
            OP_SUB_ACC:    return KIND_SUB_ACC;
            OP_CMP_ACC:    return KIND_CMP_ACC;
            OP_MOV_IMM_RM: return KIND_MOV_IMM_RM;
            default: ;
        endcase
        case (op & 8'hFC)
            OP_ARITH_IMM: return KIND_ARITH_IMM_RM;
            OP_MOV_RM:    return KIND_MOV_RM;
            OP_ADD_RM:    return KIND_ADD_RM;
            OP_SUB_RM:    return KIND_SUB_RM;
            OP_CMP_RM:    return KIND_CMP_RM;
            default: ;
        endcase
        return KIND_UNSUP;
    endfunction

    function automatic bit takes_modrm(t_kind k);
        return k <= KIND_CMP_RM || k == KIND_MOV_IMM_RM || k == KIND_ARITH_IMM_RM;
    endfunction

    function automatic int disp_bytes(t_kind k, logic [7:0] modrm);
        if (takes_modrm(k)) begin
            if (modrm[7:6] == 2'd1) return 1;
            if (modrm[7:6] == 2'd2) return 2;
            if (modrm[7:6] == 2'd0 && modrm[2:0] == 3'd6) return 2;
            return 0;
        end
        if (k == KIND_ACC_LOAD || k == KIND_ACC_STORE) return 2;
        if (k == KIND_JUMP) return 1;
        return 0;
    endfunction

    function automatic int data_bytes(t_kind k, logic [7:0] op);
        if (k == KIND_MOV_IMM_REG) return 1 + op[3];
        if (k == KIND_MOV_IMM_RM || (k >= KIND_ADD_ACC && k <= KIND_CMP_ACC)) return 1 + op[0];
        if (k == KIND_ARITH_IMM_RM) return (op[1:0] == 2'b01) ? 2 : 1;
        return 0;
    endfunction

    function automatic logic [15:0] sign_byte(logic [15:0] v);
        return {{8{v[7]}}, v[7:0]};
    endfunction

    // assemble a record from the held fields
    function automatic t_rec decoded_record(t_kind k, logic [2:0] len);
        t_rec r;
        int dl;
        r = '0;
        r.kind = k;
        r.opcode_byte = opcode_hold;
        r.length = len;
        if (k <= KIND_CMP_ACC)
            r.wide = (k == KIND_MOV_IMM_REG) ? opcode_hold[3] : opcode_hold[0];
        if (k <= KIND_CMP_RM) r.direction = opcode_hold[1];
        if (k == KIND_ARITH_IMM_RM) r.sign_extend = opcode_hold[1];
        if (takes_modrm(k)) begin
            r.mode = modrm_hold[7:6];
            r.reg_field = modrm_hold[5:3];
            r.rm_field = modrm_hold[2:0];
        end else if (k == KIND_MOV_IMM_REG) begin
            r.reg_field = opcode_hold[2:0];
        end
        if (k <= KIND_JUMP) begin
            dl = disp_bytes(k, modrm_hold);
            if (dl == 1) r.displacement = sign_byte(disp_hold);
            else if (dl == 2) r.displacement = disp_hold;
            r.immediate = data_hold;
            if (k == KIND_ARITH_IMM_RM && r.sign_extend && r.wide)
                r.immediate = sign_byte(data_hold);
            if (k == KIND_JUMP || k <= KIND_CMP_RM || k == KIND_ACC_LOAD || k == KIND_ACC_STORE)
                r.immediate = '0;
        end
        return r;
    endfunction

    // advance the shadow decoder by one code byte, 1 when a record results
    function automatic bit decode_byte(logic [7:0] b, logic eos, output t_rec r);
        t_kind k;
        int p;
        int dstart;
        int dl;
        int idx;
        r = '0;
        p = byte_count;
        if (p == 0) begin
            opcode_hold = b;
            modrm_hold = '0;
            disp_hold = '0;
            data_hold = '0;
            k = opcode_kind(b);
            if (k == KIND_UNSUP) begin
                r = decoded_record(KIND_UNSUP, 3'd1);
                return 1'b1;
            end
            if (takes_modrm(k)) needed_length = 3'd2;
            else needed_length = 3'(1 + disp_bytes(k, 8'h00) + data_bytes(k, b));
        end else begin
            k = opcode_kind(opcode_hold);
            dstart = takes_modrm(k) ? 2 : 1;
            if (takes_modrm(k) && p == 1) begin
                modrm_hold = b;
                needed_length = 3'(2 + disp_bytes(k, b) + data_bytes(k, opcode_hold));
            end else if (p >= dstart) begin
                dl = disp_bytes(k, modrm_hold);
                idx = p - dstart;
                if (idx < dl) begin
                    if (idx == 0) disp_hold[7:0] = b;
                    else disp_hold[15:8] = b;
                end else begin
                    idx -= dl;
                    if (idx == 0) data_hold[7:0] = b;
                    else if (idx == 1) data_hold[15:8] = b;
                end
            end
        end
        byte_count = 3'(p + 1);
        if (byte_count >= needed_length) begin
            r = decoded_record(k, byte_count);
            byte_count = '0;
            return 1'b1;
        end
        // stream ended inside an instruction
        if (eos) begin
            r.kind = KIND_TRUNC;
            r.opcode_byte = opcode_hold;
            r.length = byte_count;
            disp_hold = '0;
            data_hold = '0;
            modrm_hold = '0;
            byte_count = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // queue one instruction; fill < 0 gives random operand bytes
    function automatic void queue_instr(logic [7:0] op, logic [7:0] modrm, int fill,
                                        bit trunc, bit eos_end);
        t_kind k;
        int len;
        int cut;
        logic [7:0] b;
        k = opcode_kind(op);
        if (k == KIND_UNSUP) len = 1;
        else if (takes_modrm(k)) len = 2 + disp_bytes(k, modrm) + data_bytes(k, op);
        else len = 1 + disp_bytes(k, 8'h00) + data_bytes(k, op);
        cut = len;
        if (trunc && len > 1) cut = $urandom_range(1, len - 1);
        for (int i = 0; i < cut; i++) begin
            if (i == 0) b = op;
            else if (i == 1 && takes_modrm(k)) b = modrm;
            else if (fill < 0) b = 8'($urandom_range(0, 255));
            else b = fill[7:0];
            code_queue.push_back({(i == cut - 1) && (trunc || eos_end), b});
            code_total++;
        end
    endfunction

    // opcode drawn from one of the covered forms
    function automatic logic [7:0] covered_opcode();
        case ($urandom_range(0, 13))
            0:       return OP_MOV_RM | 8'($urandom_range(0, 3));
            1:       return OP_ADD_RM | 8'($urandom_range(0, 3));
            2:       return OP_SUB_RM | 8'($urandom_range(0, 3));
            3:       return OP_CMP_RM | 8'($urandom_range(0, 3));
            4:       return {OP_MOV_IMM_REG, 4'($urandom_range(0, 15))};
            5:       return OP_MOV_IMM_RM | 8'($urandom_range(0, 1));
            6:       return OP_ARITH_IMM | 8'($urandom_range(0, 3));
            7:       return OP_ACC_LOAD | 8'($urandom_range(0, 1));
            8:       return OP_ACC_STORE | 8'($urandom_range(0, 1));
            9:       return OP_ADD_ACC | 8'($urandom_range(0, 1));
            10:      return OP_SUB_ACC | 8'($urandom_range(0, 1));
            11:      return OP_CMP_ACC | 8'($urandom_range(0, 1));
            12:      return {OP_JCC, 4'($urandom_range(0, 15))};
            default: return {OP_LOOP, 2'($urandom_range(0, 3))};
        endcase
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // driver: code byte transfers and prediction
    always @(posedge i_clk) begin : driver
        t_rec rec;
        logic [8:0] item;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                code_sent++;
                if (decode_byte(s_axis_tdata, s_axis_tlast, rec))
                    pending_records.push_back(rec);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (code_queue.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    item = code_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= item[7:0];
                    s_axis_tlast <= item[8];
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: record transfers against predictions
    always @(posedge i_clk) begin : monitor
        t_rec want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_records.size() == 0) begin
                    $error("record with no instruction pending: kind %0d opcode %0h",
                           m_axis_tuser, m_axis_tdata[7:0]);
                    errors++;
                end else begin
                    want = pending_records.pop_front();
                    check_field("kind", want.kind, m_axis_tuser);
                    check_field("opcode_byte", want.opcode_byte, m_axis_tdata[7:0]);
                    check_field("wide", want.wide, m_axis_tdata[8]);
                    check_field("direction", want.direction, m_axis_tdata[9]);
                    check_field("sign_extend", want.sign_extend, m_axis_tdata[10]);
                    check_field("mode", want.mode, m_axis_tdata[12:11]);
                    check_field("reg_field", want.reg_field, m_axis_tdata[15:13]);
                    check_field("rm_field", want.rm_field, m_axis_tdata[18:16]);
                    check_field("displacement", want.displacement,
                                $signed(m_axis_tdata[34:19]));
                    check_field("immediate", want.immediate, m_axis_tdata[50:35]);
                    check_field("length", want.length, m_axis_tdata[53:51]);
                end
            end
            m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // stimulus and end of run
    initial begin : stimulus
        int directed_total;
        int pick;

        // every form with extreme operands
        queue_instr(8'h8B, 8'h06, 255, 0, 0);   // direct address
        queue_instr(8'h88, 8'h00, -1, 0, 0);
        queue_instr(8'h89, 8'h45, 128, 0, 0);   // negative byte displacement
        queue_instr(8'h03, 8'h87, 127, 0, 0);
        queue_instr(8'h2A, 8'hC1, -1, 0, 0);
        queue_instr(8'h39, 8'h7A, 0, 0, 0);
        queue_instr(8'hB0, 8'h00, 255, 0, 0);
        queue_instr(8'hBF, 8'h00, 0, 0, 0);
        queue_instr(8'hC6, 8'hC0, 255, 0, 0);   // mov immediate with register operand
        queue_instr(8'hC7, 8'h06, 128, 0, 0);
        queue_instr(8'h81, 8'h86, 255, 0, 0);   // word data
        queue_instr(8'h83, 8'h45, 128, 0, 0);   // byte data sign extended
        queue_instr(8'h82, 8'hF8, 255, 0, 0);
        queue_instr(8'hA0, 8'h00, 255, 0, 0);
        queue_instr(8'hA3, 8'h00, 0, 0, 0);
        queue_instr(8'h04, 8'h00, 255, 0, 0);
        queue_instr(8'h2D, 8'h00, 255, 0, 0);
        queue_instr(8'h3C, 8'h00, 0, 0, 0);
        queue_instr(8'h74, 8'h00, 128, 0, 0);
        queue_instr(8'hE3, 8'h00, 127, 0, 0);
        // segment moves and other unknown opcodes, one with end of stream
        queue_instr(8'h8C, 8'h00, -1, 0, 0);
        queue_instr(8'hF4, 8'h00, -1, 0, 1);
        // cut off mid instruction, and ended exactly on a boundary
        queue_instr(8'h81, 8'h86, -1, 1, 0);
        queue_instr(8'hA1, 8'h00, -1, 1, 0);
        queue_instr(8'hE2, 8'h00, -1, 0, 1);
        directed_total = code_total;

        // mostly well-formed instructions, some cut off, some noise
        while (code_total < directed_total + RANDOM_BYTES) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                code_queue.push_back({1'($urandom_range(0, 19) == 0), 8'($urandom_range(0, 255))});
                code_total++;
            end else begin
                queue_instr(covered_opcode(), 8'($urandom_range(0, 255)), -1,
                            pick < 22, $urandom_range(0, 29) == 0);
            end
        end
        queue_instr(covered_opcode(), 8'($urandom_range(0, 255)), -1, 0, 1);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (code_sent < code_total) @(posedge i_clk);
        while (pending_records.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (errors == 0 && pending_records.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            if (pending_records.size() > 0)
                $error("%0d records never arrived", pending_records.size());
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/x86d_pkg.sv
hdl/x86d_step.sv
hdl/x86_16_instruction_decoder.sv
tb/x86_16_instruction_decoder_tb.sv
